// ===== design/ttc_pkg.sv =====
package ttc_pkg;

    localparam int LVL_W = 7;
    localparam int POS_W = 12;
    localparam int PROD_W = 15;

    // op codes of the input item
    localparam logic OP_START = 1'b0;
    localparam logic OP_NEXT  = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_RING   = 3'b010,
        PH_CENTRE = 3'b100
    } t_phase;

    typedef struct packed {
        t_phase                   phase;
        logic [LVL_W-1:0]         ring_level;
        logic [1:0]               edge_sel;
        logic [2:0][LVL_W-1:0]    edge_levels;
        logic [LVL_W-1:0]         outer_step;
        logic [LVL_W-1:0]         inner_step;
        logic [POS_W-1:0]         outer_base;
        logic [POS_W-1:0]         inner_base;
    } t_walk_state;

    typedef struct packed {
        logic             tri_valid;
        logic [POS_W-1:0] corner_0;
        logic [POS_W-1:0] corner_1;
        logic [POS_W-1:0] corner_2;
        logic             last_tri;
    } t_tri;

    localparam t_walk_state WALK_RESET = '{
        phase:       PH_IDLE,
        ring_level:  '0,
        edge_sel:    '0,
        edge_levels: '0,
        outer_step:  '0,
        inner_step:  '0,
        outer_base:  '0,
        inner_base:  '0
    };

endpackage

// ===== design/ttc_walk.sv =====
module ttc_walk (
    input  logic                       i_op,
    input  logic [ttc_pkg::LVL_W-1:0]  i_inner_level,
    input  logic [ttc_pkg::LVL_W-1:0]  i_outer_level_a,
    input  logic [ttc_pkg::LVL_W-1:0]  i_outer_level_b,
    input  logic [ttc_pkg::LVL_W-1:0]  i_outer_level_c,
    input  ttc_pkg::t_walk_state       i_state,
    output ttc_pkg::t_walk_state       o_next_state,
    output ttc_pkg::t_tri              o_tri
);
    import ttc_pkg::*;

    always_comb begin
        t_walk_state      st;
        t_tri             tri_out;
        logic [LVL_W-1:0] il;
        logic [LVL_W-1:0] lv0;
        logic [LVL_W-1:0] lv1;
        logic [PROD_W-1:0] prod_o;
        logic [PROD_W-1:0] prod_i;
        logic             go_outer;

        st      = i_state;
        tri_out = '0;
        lv0     = '0;
        lv1     = '0;
        prod_o  = '0;
        prod_i  = '0;
        go_outer = 1'b0;
        il      = i_inner_level;

        if (i_op == OP_START) begin
            st = WALK_RESET;
            if (i_outer_level_a != '0 && i_outer_level_b != '0 && i_outer_level_c != '0) begin
                if (il == '0) begin
                    il = LVL_W'(1);
                end
                if (il == LVL_W'(1) && (i_outer_level_a > LVL_W'(1) ||
                        i_outer_level_b > LVL_W'(1) || i_outer_level_c > LVL_W'(1))) begin
                    il = LVL_W'(2);
                end
                st.edge_levels[0] = i_outer_level_a;
                st.edge_levels[1] = i_outer_level_b;
                st.edge_levels[2] = i_outer_level_c;
                st.ring_level     = il;
                st.inner_base     = POS_W'(i_outer_level_a) + POS_W'(i_outer_level_b)
                                  + POS_W'(i_outer_level_c) + POS_W'(1);
                // level 1 after the fixups means a lone centre triangle
                st.phase = (il > LVL_W'(1)) ? PH_RING : PH_CENTRE;
            end
        end else begin
            unique case (st.phase)
                PH_RING: begin
                    unique case (st.edge_sel)
                        2'd0:    lv0 = st.edge_levels[0];
                        2'd1:    lv0 = st.edge_levels[1];
                        default: lv0 = st.edge_levels[2];
                    endcase
                    lv1    = st.ring_level - LVL_W'(2);
                    prod_o = {{(PROD_W-LVL_W){1'b0}}, st.outer_step}
                           * {{(PROD_W-LVL_W){1'b0}}, st.ring_level};
                    prod_i = (PROD_W'(st.inner_step) + PROD_W'(1))
                           * {{(PROD_W-LVL_W){1'b0}}, lv0};
                    if (st.outer_step >= lv0) begin
                        go_outer = 1'b0;
                    end else if (st.inner_step >= lv1) begin
                        go_outer = 1'b1;
                    end else begin
                        go_outer = prod_o < prod_i;
                    end

                    tri_out.tri_valid = 1'b1;
                    if (go_outer) begin
                        tri_out.corner_0 = st.outer_base + POS_W'(st.outer_step);
                        tri_out.corner_1 = st.outer_base + POS_W'(st.outer_step) + POS_W'(1);
                        tri_out.corner_2 = st.inner_base + POS_W'(st.inner_step);
                        st.outer_step    = st.outer_step + LVL_W'(1);
                    end else begin
                        tri_out.corner_0 = st.inner_base + POS_W'(st.inner_step);
                        tri_out.corner_1 = st.outer_base + POS_W'(st.outer_step);
                        tri_out.corner_2 = st.inner_base + POS_W'(st.inner_step) + POS_W'(1);
                        st.inner_step    = st.inner_step + LVL_W'(1);
                    end

                    // edge done: move to next edge, and past the ring wrap slot
                    // after the last edge of a ring; every later edge has rows to walk
                    if (st.outer_step >= lv0 && st.inner_step >= lv1) begin
                        st.outer_base = st.outer_base + POS_W'(lv0);
                        st.inner_base = st.inner_base + POS_W'(lv1);
                        for (int i = 0; i < 3; i++) begin
                            if (st.edge_sel == 2'(i)) begin
                                st.edge_levels[i] = lv1;
                            end
                        end
                        st.outer_step = '0;
                        st.inner_step = '0;
                        if (st.edge_sel >= 2'd2) begin
                            st.edge_sel   = 2'd0;
                            st.outer_base = st.outer_base + POS_W'(1);
                            st.inner_base = st.inner_base + POS_W'(1);
                            st.ring_level = lv1;
                            if (lv1 <= LVL_W'(1)) begin
                                st.phase = (lv1 == LVL_W'(1)) ? PH_CENTRE : PH_IDLE;
                            end
                        end else begin
                            st.edge_sel = st.edge_sel + 2'd1;
                        end
                    end
                    tri_out.last_tri = (st.phase == PH_IDLE);
                end
                PH_CENTRE: begin
                    tri_out.tri_valid = 1'b1;
                    tri_out.corner_0  = st.outer_base;
                    tri_out.corner_1  = st.outer_base + POS_W'(1);
                    tri_out.corner_2  = st.outer_base + POS_W'(2);
                    tri_out.last_tri  = 1'b1;
                    st.phase          = PH_IDLE;
                end
                default: begin
                    tri_out = '0;
                end
            endcase
        end

        o_next_state = st;
        o_tri        = tri_out;
    end

endmodule

// ===== design/triangle_tess_connectivity_unit.sv =====
// Channel  Dir  Handshake                  Payload
// in       in   i_in_valid / o_in_stall    i_op, i_inner_level, i_outer_level_a/b/c
// out      out  o_out_valid / i_out_stall  o_tri_valid, o_corner_0/1/2, o_last_tri
//
// One transfer per clock on each side while that side is not stalled. A fetch
// (op = next) gives one result, from the walk state through the output
// register, or through the skid register first while the output stalls. A start gives no result.
// i_rst_n is synchronous, active low: walker idle, output and skid empty.
// A stalled output holds; one more result parks in a skid register, and the
// input stalls only while that skid register is full.
module triangle_tess_connectivity_unit #(
    parameter int MAX_LEVEL = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_op,
    input  logic [ttc_pkg::LVL_W-1:0]  i_inner_level,
    input  logic [ttc_pkg::LVL_W-1:0]  i_outer_level_a,
    input  logic [ttc_pkg::LVL_W-1:0]  i_outer_level_b,
    input  logic [ttc_pkg::LVL_W-1:0]  i_outer_level_c,

    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_tri_valid,
    output logic [ttc_pkg::POS_W-1:0]  o_corner_0,
    output logic [ttc_pkg::POS_W-1:0]  o_corner_1,
    output logic [ttc_pkg::POS_W-1:0]  o_corner_2,
    output logic                       o_last_tri
);
    import ttc_pkg::*;

    localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(MAX_LEVEL);

    t_walk_state r_state;
    t_walk_state n_state;
    t_tri        w_tri;
    t_tri        r_out;
    t_tri        r_skid;
    logic        r_out_valid;
    logic        r_skid_valid;

    logic [LVL_W-1:0] w_il;
    logic [LVL_W-1:0] w_la;
    logic [LVL_W-1:0] w_lb;
    logic [LVL_W-1:0] w_lc;
    logic             w_accept;
    logic             w_res_valid;
    logic             w_out_free;

    // levels above the maximum clamp to it
    assign w_il = (i_inner_level   > LVL_MAX) ? LVL_MAX : i_inner_level;
    assign w_la = (i_outer_level_a > LVL_MAX) ? LVL_MAX : i_outer_level_a;
    assign w_lb = (i_outer_level_b > LVL_MAX) ? LVL_MAX : i_outer_level_b;
    assign w_lc = (i_outer_level_c > LVL_MAX) ? LVL_MAX : i_outer_level_c;

    ttc_walk u_walk (
        .i_op            (i_op),
        .i_inner_level   (w_il),
        .i_outer_level_a (w_la),
        .i_outer_level_b (w_lb),
        .i_outer_level_c (w_lc),
        .i_state         (r_state),
        .o_next_state    (n_state),
        .o_tri           (w_tri)
    );

    assign o_in_stall  = r_skid_valid;
    assign w_accept    = i_in_valid && !r_skid_valid;
    // every fetch answers, also with tri_valid low
    assign w_res_valid = w_accept && (i_op == OP_NEXT);
    assign w_out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= WALK_RESET;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_state <= n_state;
            end
            if (w_out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= w_res_valid;
                end
            end else if (w_res_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_res_valid) begin
                r_out <= w_tri;
            end
        end else if (w_res_valid) begin
            r_skid <= w_tri;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_tri_valid = r_out.tri_valid;
    assign o_corner_0  = r_out.corner_0;
    assign o_corner_1  = r_out.corner_1;
    assign o_corner_2  = r_out.corner_2;
    assign o_last_tri  = r_out.last_tri;

endmodule

// ===== tb/ttc_checker.sv =====
module ttc_checker #(
    parameter int MAX_LEVEL = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic                      i_op,
    input  logic [ttc_pkg::LVL_W-1:0] i_inner_level,
    input  logic [ttc_pkg::LVL_W-1:0] i_outer_level_a,
    input  logic [ttc_pkg::LVL_W-1:0] i_outer_level_b,
    input  logic [ttc_pkg::LVL_W-1:0] i_outer_level_c,

    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic                      i_tri_valid,
    input  logic [ttc_pkg::POS_W-1:0] i_corner_0,
    input  logic [ttc_pkg::POS_W-1:0] i_corner_1,
    input  logic [ttc_pkg::POS_W-1:0] i_corner_2,
    input  logic                      i_last_tri,

    output int                        o_fail_count,
    output int                        o_pending,
    output logic                      o_walk_busy
);
    import ttc_pkg::*;

    // walker state as seen from the accepted transfers
    t_phase           walk_ph;
    logic [LVL_W-1:0] ring_lvl;
    logic [1:0]       edge_idx;
    logic [LVL_W-1:0] edge_lvl [3];
    logic [LVL_W-1:0] out_pos;
    logic [LVL_W-1:0] in_pos;
    logic [POS_W-1:0] out_row_base;
    logic [POS_W-1:0] in_row_base;

    t_tri expected_tris [$];
    int   pending_cnt;
    int   mismatch_total;

    assign o_fail_count = mismatch_total;
    assign o_pending    = pending_cnt;
    assign o_walk_busy  = (walk_ph != PH_IDLE);

    function automatic logic [LVL_W-1:0] clamp_level(logic [LVL_W-1:0] v);
        return (int'(v) > MAX_LEVEL) ? LVL_W'(MAX_LEVEL) : v;
    endfunction

    function automatic void walk_clear();
        walk_ph      = PH_IDLE;
        ring_lvl     = '0;
        edge_idx     = '0;
        edge_lvl[0]  = '0;
        edge_lvl[1]  = '0;
        edge_lvl[2]  = '0;
        out_pos      = '0;
        in_pos       = '0;
        out_row_base = '0;
        in_row_base  = '0;
    endfunction

    // move past edges whose rows are both used up, and past finished rings
    function automatic void skip_done_edges();
        int e;
        int outer_len;
        int inner_len;
        while (walk_ph == PH_RING) begin
            e         = (edge_idx > 2'd2) ? 2 : int'(edge_idx);
            outer_len = int'(edge_lvl[e]);
            inner_len = int'(ring_lvl) - 2;
            if (int'(out_pos) < outer_len || int'(in_pos) < inner_len)
                return;
            out_row_base = out_row_base + POS_W'(outer_len);
            in_row_base  = in_row_base + POS_W'(inner_len);
            edge_lvl[e]  = LVL_W'(inner_len);
            out_pos      = '0;
            in_pos       = '0;
            edge_idx     = 2'(e + 1);
            if (e == 2) begin
                edge_idx     = '0;
                out_row_base = out_row_base + POS_W'(1);
                in_row_base  = in_row_base + POS_W'(1);
                ring_lvl     = ring_lvl - LVL_W'(2);
                if (ring_lvl <= LVL_W'(1))
                    walk_ph = (ring_lvl == LVL_W'(1)) ? PH_CENTRE : PH_IDLE;
            end
        end
    endfunction

    function automatic void walk_start(logic [LVL_W-1:0] inner_raw, logic [LVL_W-1:0] a_raw,
                                       logic [LVL_W-1:0] b_raw, logic [LVL_W-1:0] c_raw);
        logic [LVL_W-1:0] il;
        logic [LVL_W-1:0] a;
        logic [LVL_W-1:0] b;
        logic [LVL_W-1:0] c;
        il = clamp_level(inner_raw);
        a  = clamp_level(a_raw);
        b  = clamp_level(b_raw);
        c  = clamp_level(c_raw);
        walk_clear();
        if (a == '0 || b == '0 || c == '0)
            return;
        if (il == '0)
            il = LVL_W'(1);
        if (il == LVL_W'(1) && (a > LVL_W'(1) || b > LVL_W'(1) || c > LVL_W'(1)))
            il = LVL_W'(2);
        edge_lvl[0] = a;
        edge_lvl[1] = b;
        edge_lvl[2] = c;
        ring_lvl    = il;
        in_row_base = POS_W'(a) + POS_W'(b) + POS_W'(c) + POS_W'(1);
        walk_ph     = (il > LVL_W'(1)) ? PH_RING : PH_CENTRE;
        skip_done_edges();
    endfunction

    function automatic t_tri walk_fetch();
        t_tri r;
        int   e;
        int   outer_len;
        int   inner_len;
        logic go_outer;
        r = '0;
        if (walk_ph == PH_RING) begin
            e         = (edge_idx > 2'd2) ? 2 : int'(edge_idx);
            outer_len = int'(edge_lvl[e]);
            inner_len = int'(ring_lvl) - 2;
            if (int'(out_pos) >= outer_len)
                go_outer = 1'b0;
            else if (int'(in_pos) >= inner_len)
                go_outer = 1'b1;
            else
                go_outer = (int'(out_pos) * (inner_len + 2)) < ((int'(in_pos) + 1) * outer_len);
            if (go_outer) begin
                r.corner_0 = out_row_base + POS_W'(out_pos);
                r.corner_1 = out_row_base + POS_W'(out_pos) + POS_W'(1);
                r.corner_2 = in_row_base + POS_W'(in_pos);
                out_pos    = out_pos + LVL_W'(1);
            end else begin
                r.corner_0 = in_row_base + POS_W'(in_pos);
                r.corner_1 = out_row_base + POS_W'(out_pos);
                r.corner_2 = in_row_base + POS_W'(in_pos) + POS_W'(1);
                in_pos     = in_pos + LVL_W'(1);
            end
            r.tri_valid = 1'b1;
            skip_done_edges();
        end else if (walk_ph == PH_CENTRE) begin
            r.corner_0  = out_row_base;
            r.corner_1  = out_row_base + POS_W'(1);
            r.corner_2  = out_row_base + POS_W'(2);
            r.tri_valid = 1'b1;
            walk_ph     = PH_IDLE;
        end
        r.last_tri = r.tri_valid && (walk_ph == PH_IDLE);
        return r;
    endfunction

    function automatic void flag_mismatch(string what, int want_v, int got_v);
        mismatch_total++;
        if (mismatch_total <= 10)
            $display("%0t ttc_checker: %s expected %0d got %0d", $time, what, want_v, got_v);
    endfunction

    initial begin
        walk_clear();
        pending_cnt    = 0;
        mismatch_total = 0;
    end

    always @(posedge i_clk) begin
        t_tri got;
        t_tri want;
        if (!i_rst_n) begin
            walk_clear();
            expected_tris.delete();
            pending_cnt = 0;
        end else begin
            // result check first: a fetch never answers in its own cycle
            if (i_out_valid && !i_out_stall) begin
                got.tri_valid = i_tri_valid;
                got.corner_0  = i_corner_0;
                got.corner_1  = i_corner_1;
                got.corner_2  = i_corner_2;
                got.last_tri  = i_last_tri;
                if (expected_tris.size() == 0) begin
                    flag_mismatch("surplus result, tri_valid", 0, int'(got.tri_valid));
                end else begin
                    want = expected_tris.pop_front();
                    pending_cnt--;
                    if (got.tri_valid !== want.tri_valid)
                        flag_mismatch("tri_valid", int'(want.tri_valid), int'(got.tri_valid));
                    if (got.corner_0 !== want.corner_0)
                        flag_mismatch("corner_0", int'(want.corner_0), int'(got.corner_0));
                    if (got.corner_1 !== want.corner_1)
                        flag_mismatch("corner_1", int'(want.corner_1), int'(got.corner_1));
                    if (got.corner_2 !== want.corner_2)
                        flag_mismatch("corner_2", int'(want.corner_2), int'(got.corner_2));
                    if (got.last_tri !== want.last_tri)
                        flag_mismatch("last_tri", int'(want.last_tri), int'(got.last_tri));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_op == OP_START) begin
                    walk_start(i_inner_level, i_outer_level_a, i_outer_level_b,
                               i_outer_level_c);
                end else begin
                    expected_tris.push_back(walk_fetch());
                    pending_cnt++;
                end
            end
        end
    end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import ttc_pkg::*;

    localparam int ITEM_TARGET = 1450;

    logic             i_clk;
    logic             i_rst_n;

    // input channel
    logic             i_in_valid;
    logic             o_in_stall;
    logic             i_op;
    logic [LVL_W-1:0] i_inner_level;
    logic [LVL_W-1:0] i_outer_level_a;
    logic [LVL_W-1:0] i_outer_level_b;
    logic [LVL_W-1:0] i_outer_level_c;

    // output channel
    logic             o_out_valid;
    logic             i_out_stall;
    logic             o_tri_valid;
    logic [POS_W-1:0] o_corner_0;
    logic [POS_W-1:0] o_corner_1;
    logic [POS_W-1:0] o_corner_2;
    logic             o_last_tri;

    int               fail_count;
    int               pending;
    logic             walk_busy;

    int               sent_items;
    logic             in_burst;     // sender runs back to back while set
    logic             out_burst;    // receiver never stalls while set

    triangle_tess_connectivity_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_inner_level   (i_inner_level),
        .i_outer_level_a (i_outer_level_a),
        .i_outer_level_b (i_outer_level_b),
        .i_outer_level_c (i_outer_level_c),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_tri_valid     (o_tri_valid),
        .o_corner_0      (o_corner_0),
        .o_corner_1      (o_corner_1),
        .o_corner_2      (o_corner_2),
        .o_last_tri      (o_last_tri)
    );

    // checker watches both channels, keeps its own walker and compares
    ttc_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_inner_level   (i_inner_level),
        .i_outer_level_a (i_outer_level_a),
        .i_outer_level_b (i_outer_level_b),
        .i_outer_level_c (i_outer_level_c),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_tri_valid     (o_tri_valid),
        .i_corner_0      (o_corner_0),
        .i_corner_1      (o_corner_1),
        .i_corner_2      (o_corner_2),
        .i_last_tri      (o_last_tri),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_walk_busy     (walk_busy)
    );

    always #5 i_clk = ~i_clk;

    // One transfer on the input channel. Entered and left at a falling edge,
    // so walk_busy is settled when the caller looks at it. A random gap, drawn
    // unless in_burst is set, drops valid first; with no gap valid stays high across items.
    task automatic send_item(input logic op, input logic [LVL_W-1:0] inner,
                             input logic [LVL_W-1:0] oa, input logic [LVL_W-1:0] ob,
                             input logic [LVL_W-1:0] oc);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_op            <= op;
        i_inner_level   <= inner;
        i_outer_level_a <= oa;
        i_outer_level_b <= ob;
        i_outer_level_c <= oc;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        sent_items++;
    endtask

    // fetch carries random level bits; the block must ignore them
    task automatic fetch_tri();
        send_item(OP_NEXT, LVL_W'($urandom_range(0, 127)), LVL_W'($urandom_range(0, 127)),
                  LVL_W'($urandom_range(0, 127)), LVL_W'($urandom_range(0, 127)));
    endtask

    // keep fetching while the predicted walk still has triangles, up to cap
    task automatic fetch_walk(input int cap);
        int n;
        n = 0;
        while (walk_busy && n < cap) begin
            fetch_tri();
            n++;
        end
    endtask

    task automatic start_patch(input int inner, input int oa, input int ob, input int oc);
        send_item(OP_START, LVL_W'(inner), LVL_W'(oa), LVL_W'(ob), LVL_W'(oc));
    endtask

    // receiver: draws a stall length per result, occasionally switches to a
    // no-stall stretch and back
    initial begin
        int hold;
        out_burst   = 1'b0;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 49) == 0)
                out_burst = !out_burst;
            hold = out_burst ? 0 : $urandom_range(0, 10);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        int kind;
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_op            = OP_NEXT;
        i_inner_level   = '0;
        i_outer_level_a = '0;
        i_outer_level_b = '0;
        i_outer_level_c = '0;
        sent_items      = 0;
        in_burst        = 1'b0;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part ----
        fetch_tri();                        // nothing started yet
        start_patch(5, 0, 3, 3);            // culled on edge 0
        fetch_tri();
        start_patch(127, 127, 127, 0);      // culled on edge 2, over-range levels
        fetch_tri();
        start_patch(1, 1, 1, 1);            // lone centre triangle
        fetch_tri();
        fetch_tri();                        // after the last triangle
        start_patch(0, 1, 1, 1);            // inner 0 behaves as inner 1
        fetch_tri();
        start_patch(1, 2, 1, 1);            // inner 1 promoted to 2, fan to centre
        fetch_walk(10);
        start_patch(3, 1, 1, 1);            // odd inner: ring then centre triangle
        fetch_walk(10);
        start_patch(127, 127, 64, 65);      // saturation to the max level
        fetch_tri();
        fetch_tri();
        start_patch(100, 127, 127, 127);    // restart mid-walk
        fetch_tri();

        // ---- random part ----
        while (sent_items < ITEM_TARGET) begin
            in_burst = ($urandom_range(0, 3) == 0);
            kind     = $urandom_range(0, 99);
            if (kind < 8) begin
                fetch_tri();
            end else if (kind < 20) begin
                // raw 7-bit levels, walk usually abandoned by a later start
                start_patch($urandom_range(0, 127), $urandom_range(0, 127),
                            $urandom_range(0, 127), $urandom_range(0, 127));
                fetch_walk($urandom_range(0, 30));
            end else if (kind < 30) begin
                // one outer level forced to zero
                case ($urandom_range(0, 2))
                    0: start_patch($urandom_range(0, 64), 0, $urandom_range(0, 64),
                                   $urandom_range(0, 64));
                    1: start_patch($urandom_range(0, 64), $urandom_range(0, 64), 0,
                                   $urandom_range(0, 64));
                    default: start_patch($urandom_range(0, 64), $urandom_range(0, 64),
                                         $urandom_range(0, 64), 0);
                endcase
                repeat ($urandom_range(0, 2)) fetch_tri();
            end else if (kind < 40) begin
                start_patch($urandom_range(0, 16), $urandom_range(1, 16),
                            $urandom_range(1, 16), $urandom_range(1, 16));
                fetch_walk(1000);
            end else begin
                // small patches; a quarter of them cut short
                start_patch($urandom_range(0, 6), $urandom_range(1, 8),
                            $urandom_range(1, 8), $urandom_range(1, 8));
                if ($urandom_range(0, 3) == 0)
                    fetch_walk($urandom_range(0, 20));
                else
                    fetch_walk(1000);
            end
            if ($urandom_range(0, 9) < 3)
                repeat ($urandom_range(1, 2)) fetch_tri();
        end

        // drain: wait for every predicted triangle, then a short tail
        i_in_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/ttc_pkg.sv
design/ttc_walk.sv
design/triangle_tess_connectivity_unit.sv
tb/ttc_checker.sv
tb/tb_top.sv
